### hdl/bsr_pkg.sv
`default_nettype none

package bsr_pkg;

   // fixed point format of value, root and tolerance
   localparam int unsigned FIX_W     = 40;
   localparam int unsigned FRAC_BITS = 16;

   // iteration limit and width of the step count
   localparam int unsigned MAX_ITER = 64;
   localparam int unsigned ITER_W   = $clog2(MAX_ITER + 1);
   localparam logic [ITER_W-1:0] MAX_ITER_C = ITER_W'(MAX_ITER);

   // digit-serial squarer: one cell per operand digit
   localparam int unsigned DIG_W   = 16;
   localparam int unsigned NUM_DIG = (FIX_W + DIG_W - 1) / DIG_W;
   localparam int unsigned OPND_W  = NUM_DIG * DIG_W;
   localparam int unsigned PROD_W  = 2 * OPND_W;
   localparam int unsigned SQ_W    = 2 * FIX_W;
   localparam int unsigned DIFF_W  = SQ_W + 1;
   localparam int unsigned MUL_CYC = 2 * NUM_DIG;
   localparam int unsigned CYC_W   = $clog2(MUL_CYC + 1);

   // 1.0 in fixed point and the tolerance after reset
   localparam logic [FIX_W-1:0] ONE_FX    = FIX_W'(1) << FRAC_BITS;
   localparam logic [FIX_W-1:0] TOL_RESET = FIX_W'(6554);

   // register port
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned REG_SEL_BIT = 3;
   localparam logic        REG_TOLERANCE = 1'b0;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MULT,
      ST_DIFF,
      ST_CHECK
   } state_type;

   // control from the sequencer to the squarer and its cells
   typedef struct packed {
      logic load;
      logic step;
   } sq_ctrl_type;

endpackage

`default_nettype wire

### hdl/bsr_cell.sv
`default_nettype none

module bsr_cell
   import bsr_pkg::*;
(
   input  wire logic              clock,
   input  wire sq_ctrl_type       ctrl,
   input  wire logic [DIG_W-1:0]  a_digit,
   input  wire logic [DIG_W-1:0]  b_digit,
   input  wire logic [DIG_W-1:0]  upper_digit,
   output logic      [DIG_W-1:0]  lower_digit
);

   logic [DIG_W-1:0]   sum_ff;
   logic [DIG_W-1:0]   sum_in;
   logic [DIG_W:0]     carry_ff;
   logic [DIG_W:0]     carry_in;
   logic [2*DIG_W:0]   total;

   // partial product plus the digit handed down plus own carry
   always_comb begin
      total = (2*DIG_W+1)'(a_digit * b_digit)
            + (2*DIG_W+1)'(sum_ff)
            + (2*DIG_W+1)'(carry_ff);
   end

   // low digit goes to the lower neighbor, high part stays here
   assign lower_digit = total[DIG_W-1:0];

   always_comb begin
      sum_in   = sum_ff;
      carry_in = carry_ff;
      if (ctrl.load) begin
         sum_in   = '0;
         carry_in = '0;
      end else if (ctrl.step) begin
         sum_in   = upper_digit;
         carry_in = total[2*DIG_W:DIG_W];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      carry_ff <= carry_in;
   end

endmodule

`default_nettype wire

### hdl/bsr_square.sv
`default_nettype none

module bsr_square
   import bsr_pkg::*;
(
   input  wire logic              clock,
   input  wire sq_ctrl_type       ctrl,
   input  wire logic [FIX_W-1:0]  operand,
   output logic      [SQ_W-1:0]   square
);

   logic [OPND_W-1:0]  opa_ff;
   logic [OPND_W-1:0]  opa_in;
   logic [OPND_W-1:0]  opb_ff;
   logic [OPND_W-1:0]  opb_in;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_in;
   logic [DIG_W-1:0]   link [NUM_DIG+1];

   // nothing enters the top cell from above
   assign link[NUM_DIG] = '0;

   // row of cells, each holding one digit of the multiplicand
   for (genvar k = 0; k < NUM_DIG; k++) begin : g_cell
      bsr_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .a_digit     (opa_ff[k*DIG_W +: DIG_W]),
         .b_digit     (opb_ff[DIG_W-1:0]),
         .upper_digit (link[k+1]),
         .lower_digit (link[k])
      );
   end

   // multiplier digits enter low first, product digits leave low first
   always_comb begin
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      prod_in = prod_ff;
      if (ctrl.load) begin
         opa_in = OPND_W'(operand);
         opb_in = OPND_W'(operand);
      end else if (ctrl.step) begin
         opb_in  = opb_ff >> DIG_W;
         prod_in = {link[0], prod_ff[PROD_W-1:DIG_W]};
      end
   end

   always_ff @(posedge clock) begin
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      prod_ff <= prod_in;
   end

   assign square = prod_ff[SQ_W-1:0];

endmodule

`default_nettype wire

### hdl/bsr_csr.sv
`default_nettype none

module bsr_csr
   import bsr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output logic      [CSR_DATA_W-1:0]  prdata,
   output logic                        pready,
   output logic      [FIX_W-1:0]       tolerance
);

   logic [FIX_W-1:0] tol_ff;
   logic [FIX_W-1:0] tol_in;
   logic             reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[REG_SEL_BIT] == REG_TOLERANCE);

   // register write in the access phase
   always_comb begin
      tol_in = tol_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         tol_in = pwdata[FIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   // read back
   assign prdata    = reg_hit ? CSR_DATA_W'(tol_ff) : '0;
   assign tolerance = tol_ff;

endmodule

`default_nettype wire

### hdl/bisection_square_root.sv
`default_nettype none

// Bisection square root of an unsigned Q24.16 value.
// A transaction is accepted at a rising edge with start high and busy low;
// busy stays high until the result has been issued. The result (root,
// step count, gave-up flag) is driven for exactly one cycle with rsp_valid
// high; the receiver cannot hold it off.
// Value zero and value 1.0 are exact endpoints: the result is issued in
// the cycle after acceptance and busy does not rise.
// Any other value runs the halving loop. Each pass forms the midpoint,
// squares it in the digit-serial squarer (a row of 3 cells of 16x16
// multipliers, 3 digits in and 6 product digits out), forms the difference
// to the target and tests it against the tolerance. The loop ends when the
// square is within the tolerance or, with the gave-up flag set, after 64
// halving steps; busy falls in the cycle of rsp_valid, so a new value may
// be started then. The tolerance register sits at byte address 0 of the
// register port; the user must write it only while the block is not busy,
// and the block itself does not enforce that.
// Reset returns the sequencer to idle, drops rsp_valid and loads the
// tolerance with 6554 (about 0.1).
module bisection_square_root
   import bsr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [FIX_W-1:0]       req_value,
   output logic                        rsp_valid,
   output logic      [FIX_W-1:0]       rsp_root,
   output logic      [ITER_W-1:0]      rsp_iterations,
   output logic                        rsp_gave_up,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output logic      [CSR_DATA_W-1:0]  prdata,
   output logic                        pready
);

   state_type          state_ff;
   state_type          state_in;
   logic [CYC_W-1:0]   cyc_ff;
   logic [CYC_W-1:0]   cyc_in;
   logic [FIX_W-1:0]   value_ff;
   logic [FIX_W-1:0]   value_in;
   logic [FIX_W-1:0]   lo_ff;
   logic [FIX_W-1:0]   lo_in;
   logic [FIX_W-1:0]   hi_ff;
   logic [FIX_W-1:0]   hi_in;
   logic [FIX_W-1:0]   mid_ff;
   logic [FIX_W-1:0]   mid_in;
   logic [ITER_W-1:0]  steps_ff;
   logic [ITER_W-1:0]  steps_in;
   logic [DIFF_W-1:0]  diff_ff;
   logic [DIFF_W-1:0]  diff_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [FIX_W-1:0]   rsp_root_ff;
   logic [FIX_W-1:0]   rsp_root_in;
   logic [ITER_W-1:0]  rsp_iter_ff;
   logic [ITER_W-1:0]  rsp_iter_in;
   logic               rsp_gave_ff;
   logic               rsp_gave_in;

   sq_ctrl_type        sq_ctrl;
   logic [SQ_W-1:0]    square;
   logic [FIX_W-1:0]   tolerance;
   logic [FIX_W:0]     mid_sum;
   logic [FIX_W-1:0]   mid_calc;
   logic [FIX_W-1:0]   hi_init;
   logic [SQ_W-1:0]    target_wide;
   logic [SQ_W-1:0]    tol_wide;
   logic [DIFF_W-1:0]  diff_calc;
   logic               below;
   logic [SQ_W-1:0]    magnitude;
   logic               in_tol;

   localparam logic [CYC_W-1:0] LAST_CYC = CYC_W'(MUL_CYC - 1);

   // register port
   bsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .tolerance (tolerance)
   );

   // digit-serial squarer
   bsr_square u_square (
      .clock   (clock),
      .ctrl    (sq_ctrl),
      .operand (mid_in),
      .square  (square)
   );

   // midpoint and initial upper bound
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = mid_sum[FIX_W:1];
   assign hi_init  = (req_value > ONE_FX) ? req_value : ONE_FX;

   // target and tolerance aligned to the square's fraction bits
   assign target_wide = SQ_W'(value_ff) << FRAC_BITS;
   assign tol_wide    = SQ_W'(tolerance) << FRAC_BITS;
   assign diff_calc   = {1'b0, square} - {1'b0, target_wide};

   // tolerance test on the registered difference
   assign below     = diff_ff[DIFF_W-1];
   assign magnitude = below ? (SQ_W'(0) - diff_ff[SQ_W-1:0]) : diff_ff[SQ_W-1:0];
   assign in_tol    = (magnitude <= tol_wide);

   // sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      cyc_in       = cyc_ff;
      value_in     = value_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      steps_in     = steps_ff;
      diff_in      = diff_ff;
      rsp_valid_in = 1'b0;
      rsp_root_in  = rsp_root_ff;
      rsp_iter_in  = rsp_iter_ff;
      rsp_gave_in  = rsp_gave_ff;
      sq_ctrl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = req_value;
               lo_in    = '0;
               hi_in    = hi_init;
               steps_in = '0;
               if (req_value == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_root_in  = '0;
                  rsp_iter_in  = '0;
                  rsp_gave_in  = 1'b0;
               end else if (req_value == ONE_FX) begin
                  rsp_valid_in = 1'b1;
                  rsp_root_in  = ONE_FX;
                  rsp_iter_in  = '0;
                  rsp_gave_in  = 1'b0;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            mid_in       = mid_calc;
            sq_ctrl.load = 1'b1;
            cyc_in       = '0;
            state_in     = ST_MULT;
         end
         ST_MULT: begin
            sq_ctrl.step = 1'b1;
            cyc_in       = cyc_ff + CYC_W'(1);
            if (cyc_ff == LAST_CYC) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            diff_in  = diff_calc;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (in_tol) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = mid_ff;
               rsp_iter_in  = steps_ff;
               rsp_gave_in  = 1'b0;
               state_in     = ST_IDLE;
            end else if (steps_ff >= MAX_ITER_C) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = mid_ff;
               rsp_iter_in  = steps_ff;
               rsp_gave_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               steps_in = steps_ff + ITER_W'(1);
               if (below) begin
                  lo_in = mid_ff;
               end else begin
                  hi_in = mid_ff;
               end
               state_in = ST_SETUP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cyc_ff      <= cyc_in;
      value_ff    <= value_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      steps_ff    <= steps_in;
      diff_ff     <= diff_in;
      rsp_root_ff <= rsp_root_in;
      rsp_iter_ff <= rsp_iter_in;
      rsp_gave_ff <= rsp_gave_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_root       = rsp_root_ff;
   assign rsp_iterations = rsp_iter_ff;
   assign rsp_gave_up    = rsp_gave_ff;

endmodule

`default_nettype wire
